### hw/rtl/rsc_pkg.sv
// ----------------------------------------------------------------------------
// rsc_pkg: shared types and constants of the rpn stack calculator
// operation codes, status codes, state encodings and the alu request bundle
// ----------------------------------------------------------------------------
package rsc_pkg;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned BIT_CNT_W = 5;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned DEPTH_W = 5;
  localparam int unsigned S_TDATA_W = 40;
  localparam int unsigned M_TDATA_W = 48;

  typedef enum logic [2:0] {
    MODE_PUSH = 3'd0,
    MODE_ADD  = 3'd1,
    MODE_SUB  = 3'd2,
    MODE_MUL  = 3'd3,
    MODE_DIV  = 3'd4,
    MODE_TOP  = 3'd5
  } mode_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK    = 3'd0,
    STATUS_FULL  = 3'd1,
    STATUS_EMPTY = 3'd2,
    STATUS_FEW   = 3'd3,
    STATUS_DIV0  = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_RUN
  } ctrl_state_e;

  typedef enum logic [1:0] {
    ALU_IDLE,
    ALU_PREP,
    ALU_RUN,
    ALU_FIX
  } alu_state_e;

  typedef struct packed {
    logic  start;
    mode_e op;
  } alu_req_t;

endpackage

### hw/rtl/rsc_stack.sv
// ----------------------------------------------------------------------------
// rsc_stack: operand storage below the top of stack
// single write port, single registered read port
// ----------------------------------------------------------------------------
module rsc_stack #(
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  logic                       clk_i,
  input  logic                       wr_en_i,
  input  logic [AddrW-1:0]           wr_addr_i,
  input  logic [rsc_pkg::DATA_W-1:0] wr_data_i,
  input  logic                       rd_en_i,
  input  logic [AddrW-1:0]           rd_addr_i,
  output logic [rsc_pkg::DATA_W-1:0] rd_data_o
);

  logic [rsc_pkg::DATA_W-1:0] mem_q [Depth];
  logic [rsc_pkg::DATA_W-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

### hw/rtl/rsc_alu.sv
// ----------------------------------------------------------------------------
// rsc_alu: serial arithmetic unit
// one bit per cycle: ripple add/subtract, shift-add multiply, restoring divide
// ----------------------------------------------------------------------------
module rsc_alu (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  rsc_pkg::alu_req_t          req_i,
  input  logic [rsc_pkg::DATA_W-1:0] a_i,
  input  logic [rsc_pkg::DATA_W-1:0] b_i,
  output logic                       done_o,
  output logic [rsc_pkg::DATA_W-1:0] res_o
);

  localparam int unsigned W = rsc_pkg::DATA_W;

  rsc_pkg::alu_state_e            state_q, state_d;
  rsc_pkg::mode_e                 op_q, op_d;
  logic [rsc_pkg::BIT_CNT_W-1:0]  cnt_q, cnt_d;
  logic [W-1:0]                   a_q, a_d;
  logic [W-1:0]                   b_q, b_d;
  logic [W-1:0]                   acc_q, acc_d;
  logic [W-1:0]                   rem_q, rem_d;
  logic                           carry_q, carry_d;
  logic                           neg_q, neg_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rsc_pkg::ALU_IDLE;
      op_q    <= rsc_pkg::MODE_ADD;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q     <= a_d;
    b_q     <= b_d;
    acc_q   <= acc_d;
    rem_q   <= rem_d;
    carry_q <= carry_d;
    neg_q   <= neg_d;
  end

  always_comb begin
    logic         bb;
    logic [W:0]   rem_t;
    logic [W:0]   diff;
    state_d = state_q;
    op_d    = op_q;
    cnt_d   = cnt_q;
    a_d     = a_q;
    b_d     = b_q;
    acc_d   = acc_q;
    rem_d   = rem_q;
    carry_d = carry_q;
    neg_d   = neg_q;
    bb      = 1'b0;
    rem_t   = '0;
    diff    = '0;
    case (state_q)
      rsc_pkg::ALU_IDLE: begin
        if (req_i.start) begin
          op_d    = req_i.op;
          a_d     = a_i;
          b_d     = b_i;
          state_d = rsc_pkg::ALU_PREP;
        end
      end
      rsc_pkg::ALU_PREP: begin
        acc_d   = '0;
        rem_d   = '0;
        cnt_d   = '0;
        carry_d = (op_q == rsc_pkg::MODE_SUB);
        neg_d   = a_q[W-1] ^ b_q[W-1];
        if (op_q == rsc_pkg::MODE_DIV) begin
          a_d = a_q[W-1] ? (W'(0) - a_q) : a_q;
          b_d = b_q[W-1] ? (W'(0) - b_q) : b_q;
        end
        state_d = rsc_pkg::ALU_RUN;
      end
      rsc_pkg::ALU_RUN: begin
        case (op_q)
          rsc_pkg::MODE_ADD, rsc_pkg::MODE_SUB: begin
            bb      = (op_q == rsc_pkg::MODE_SUB) ? ~b_q[0] : b_q[0];
            acc_d   = {a_q[0] ^ bb ^ carry_q, acc_q[W-1:1]};
            carry_d = (a_q[0] & bb) | (a_q[0] & carry_q) | (bb & carry_q);
            a_d     = {1'b0, a_q[W-1:1]};
            b_d     = {1'b0, b_q[W-1:1]};
          end
          rsc_pkg::MODE_MUL: begin
            acc_d = acc_q + (b_q[0] ? a_q : W'(0));
            a_d   = {a_q[W-2:0], 1'b0};
            b_d   = {1'b0, b_q[W-1:1]};
          end
          rsc_pkg::MODE_DIV: begin
            rem_t = {rem_q, a_q[W-1]};
            diff  = rem_t - {1'b0, b_q};
            if (!diff[W]) begin
              rem_d = diff[W-1:0];
              acc_d = {acc_q[W-2:0], 1'b1};
            end else begin
              rem_d = rem_t[W-1:0];
              acc_d = {acc_q[W-2:0], 1'b0};
            end
            a_d = {a_q[W-2:0], 1'b0};
          end
          default: begin
            acc_d = acc_q;
          end
        endcase
        cnt_d = cnt_q + rsc_pkg::BIT_CNT_W'(1);
        if (cnt_q == rsc_pkg::BIT_CNT_W'(W - 1)) begin
          state_d = rsc_pkg::ALU_FIX;
        end
      end
      rsc_pkg::ALU_FIX: begin
        state_d = rsc_pkg::ALU_IDLE;
      end
      default: begin
        state_d = rsc_pkg::ALU_IDLE;
      end
    endcase
  end

  assign done_o = (state_q == rsc_pkg::ALU_FIX);
  assign res_o  = ((op_q == rsc_pkg::MODE_DIV) && neg_q) ? (W'(0) - acc_q) : acc_q;

endmodule

### hw/rtl/rpn_stack_calculator_unit.sv
// ----------------------------------------------------------------------------
// rpn_stack_calculator_unit: reverse polish integer calculator
// bounded operand stack with serial add, subtract, multiply and divide
// ----------------------------------------------------------------------------
// usage
//   slave stream: one transaction per command, tdata holds mode and value
//   master stream: one transaction per command with status, top of stack,
//   top valid flag and depth after the command
//   push, read top, refused and ignored commands answer in the cycle after
//   acceptance, so one such command can be taken every cycle the output is
//   free
//   add, subtract, multiply and divide read the second entry from the stack
//   memory, then run the serial alu through its setup state, the bit loop over
//   all 32 operand bits and a result state; the answer is registered when the
//   alu finishes, and no new command is taken before it
//   the alu bit loop takes one bit per cycle over 32 bits
//   reset empties the stack; stack contents need no clearing
//   while a result waits on a stalled receiver no new command is taken
// ----------------------------------------------------------------------------
module rpn_stack_calculator_unit #(
  parameter int unsigned STACK_DEPTH = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // mode [2:0], value [34:3]
  input  logic [rsc_pkg::S_TDATA_W-1:0]   s_axis_tdata,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // status [2:0], top_value [34:3], top_valid [35], depth [40:36]
  output logic [rsc_pkg::M_TDATA_W-1:0]   m_axis_tdata
);

  localparam int unsigned CW = $clog2(STACK_DEPTH + 1);
  localparam int unsigned AW = $clog2(STACK_DEPTH);
  localparam int unsigned W  = rsc_pkg::DATA_W;

  rsc_pkg::ctrl_state_e state_q, state_d;
  logic [CW-1:0]        cnt_q, cnt_d;
  logic [W-1:0]         top_q, top_d;
  logic                 out_vld_q, out_vld_d;
  rsc_pkg::status_e     out_status_q, status_d;
  logic [W-1:0]         out_top_q;
  logic                 out_tvld_q;
  logic [rsc_pkg::DEPTH_W-1:0] out_depth_q;
  logic                 out_load;
  rsc_pkg::mode_e       alu_op_q, alu_op_d;

  rsc_pkg::mode_e       in_mode;
  logic [W-1:0]         in_value;
  logic                 s_fire;
  logic [CW-1:0]        cnt_m1;
  logic [CW-1:0]        cnt_m2;

  logic                 wr_en;
  logic [AW-1:0]        wr_addr;
  logic                 rd_en;
  logic [W-1:0]         rd_data;
  rsc_pkg::alu_req_t    alu_req;
  logic                 alu_done;
  logic [W-1:0]         alu_res;

  assign in_mode  = rsc_pkg::mode_e'(s_axis_tdata[2:0]);
  assign in_value = s_axis_tdata[34:3];
  assign s_axis_tready = (state_q == rsc_pkg::ST_IDLE) && (!out_vld_q || m_axis_tready);
  assign s_fire = s_axis_tvalid && s_axis_tready;
  assign cnt_m1 = cnt_q - CW'(1);
  assign cnt_m2 = cnt_q - CW'(2);

  rsc_stack #(
    .Depth(STACK_DEPTH)
  ) u_stack (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (top_q),
    .rd_en_i   (rd_en),
    .rd_addr_i (cnt_m2[AW-1:0]),
    .rd_data_o (rd_data)
  );

  rsc_alu u_alu (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (alu_req),
    .a_i    (rd_data),
    .b_i    (top_q),
    .done_o (alu_done),
    .res_o  (alu_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= rsc_pkg::ST_IDLE;
      cnt_q     <= '0;
      out_vld_q <= 1'b0;
      alu_op_q  <= rsc_pkg::MODE_ADD;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      out_vld_q <= out_vld_d;
      alu_op_q  <= alu_op_d;
    end
  end

  always_ff @(posedge clk_i) begin
    top_q <= top_d;
    if (out_load) begin
      out_status_q <= status_d;
      out_top_q    <= (cnt_d != '0) ? top_d : W'(0);
      out_tvld_q   <= (cnt_d != '0);
      out_depth_q  <= rsc_pkg::DEPTH_W'(cnt_d);
    end
  end

  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    top_d    = top_q;
    alu_op_d = alu_op_q;
    status_d = rsc_pkg::STATUS_OK;
    out_load = 1'b0;
    out_vld_d = out_vld_q && !m_axis_tready;
    wr_en    = 1'b0;
    wr_addr  = cnt_m1[AW-1:0];
    rd_en    = 1'b0;
    alu_req.start = 1'b0;
    alu_req.op    = alu_op_q;
    case (state_q)
      rsc_pkg::ST_IDLE: begin
        if (s_fire) begin
          out_load = 1'b1;
          case (in_mode)
            rsc_pkg::MODE_PUSH: begin
              if (cnt_q == CW'(STACK_DEPTH)) begin
                status_d = rsc_pkg::STATUS_FULL;
              end else begin
                wr_en = (cnt_q != '0);
                top_d = in_value;
                cnt_d = cnt_q + CW'(1);
              end
            end
            rsc_pkg::MODE_ADD, rsc_pkg::MODE_SUB, rsc_pkg::MODE_MUL,
            rsc_pkg::MODE_DIV: begin
              if (cnt_q < CW'(2)) begin
                status_d = rsc_pkg::STATUS_FEW;
              end else if ((in_mode == rsc_pkg::MODE_DIV) && (top_q == W'(0))) begin
                status_d = rsc_pkg::STATUS_DIV0;
              end else begin
                out_load = 1'b0;
                rd_en    = 1'b1;
                alu_op_d = in_mode;
                state_d  = rsc_pkg::ST_READ;
              end
            end
            rsc_pkg::MODE_TOP: begin
              if (cnt_q == '0) begin
                status_d = rsc_pkg::STATUS_EMPTY;
              end
            end
            default: begin
              status_d = rsc_pkg::STATUS_OK;
            end
          endcase
          out_vld_d = out_load || (out_vld_q && !m_axis_tready);
        end
      end
      rsc_pkg::ST_READ: begin
        alu_req.start = 1'b1;
        state_d       = rsc_pkg::ST_RUN;
      end
      rsc_pkg::ST_RUN: begin
        if (alu_done) begin
          top_d     = alu_res;
          cnt_d     = cnt_m1;
          out_load  = 1'b1;
          out_vld_d = 1'b1;
          state_d   = rsc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = rsc_pkg::ST_IDLE;
      end
    endcase
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {7'b0, out_depth_q, out_tvld_q, out_top_q, out_status_q};

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(STACK_DEPTH))
    else $error("stack count beyond depth");

  a_stall_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && !m_axis_tready) |-> !s_axis_tready)
    else $error("command taken while result stalled");

  a_done_in_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    alu_done |-> (state_q == rsc_pkg::ST_RUN))
    else $error("alu result outside run state");

  a_read_to_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == rsc_pkg::ST_READ) |=> (state_q == rsc_pkg::ST_RUN))
    else $error("operand read not followed by alu run");

  a_op_needs_two: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == rsc_pkg::ST_READ) |-> (cnt_q >= CW'(2)))
    else $error("alu started with fewer than two operands");
`endif

endmodule
